FILE: hw/rtl/pcbp_pkg.sv
// types and constants for the prefix code bit packer
package pcbp_pkg;

    localparam int KIND_W  = 2;
    localparam int SYM_W   = 7;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int ACC_W   = 40;
    localparam int MAX_OUT = 4;
    localparam int OUT_CNT_W = 3;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } out_item_t;

endpackage

FILE: hw/rtl/prefix_code_bit_packer_unit.sv
// prefix code bit packer: code table, bit accumulator and byte output queue
// path: an encode or flush goes through the input stage and table read stage registers into the output queue
// throughput: one transaction per cycle while the output queue is free; an encode or flush waits for
//   the queue to drain, and the single byte-wide output port carries up to four bytes per symbol
// the code table is a memory of up to 128 entries, read from the input stage into the table read stage
// reset: accumulator, pending count and all valid flags clear; the table keeps garbage
module prefix_code_bit_packer_unit
    import pcbp_pkg::*;
#(
    parameter int ALPHABET_SIZE = 128,
    parameter int MAX_CODE_LEN  = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    localparam int TABLE_DEPTH = (ALPHABET_SIZE > (1 << SYM_W)) ? (1 << SYM_W) : ALPHABET_SIZE;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_LIMIT   = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    logic [CODE_W-1:0] code_mem [TABLE_DEPTH];
    logic [LEN_W-1:0]  len_mem  [TABLE_DEPTH];

    // input stage
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      s1_adv;
    logic      s1_ok;
    logic [IDX_W-1:0]  s1_idx;
    logic [LEN_W-1:0]  s1_len;
    logic [CODE_W:0]   s1_mask;
    logic [CODE_W-1:0] s1_code;

    // table read stage
    logic              s2_valid_reg;
    logic [KIND_W-1:0] s2_kind_reg;
    logic              s2_ok_reg;
    logic [CODE_W-1:0] code_rd_reg;
    logic [LEN_W-1:0]  len_rd_reg;
    logic              s2_needs_out;
    logic              s2_fire;

    // accumulator
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [LEN_W-1:0] pend_reg, pend_next;

    // output queue
    out_item_t            res_reg [MAX_OUT];
    out_item_t            res_next [MAX_OUT];
    logic [OUT_CNT_W-1:0] res_left_reg, res_left_next;
    logic                 res_take;
    logic                 buf_free;

    // encode datapath
    logic [LEN_W-1:0]     pend_sum;
    logic [ACC_W-1:0]     acc_sum;
    logic [ACC_W-1:0]     aligned;
    logic [OUT_CNT_W-1:0] n_out;
    logic [LEN_W-1:0]     pend_rem;
    logic [LEN_W-1:0]     pend_m1;
    logic [BYTE_W-1:0]    flush_byte;
    logic [BYTE_W-1:0]    pad_byte;

    assign res_take     = result_valid && result_ready;
    assign buf_free     = (res_left_reg == '0) || ((res_left_reg == OUT_CNT_W'(1)) && result_ready);
    assign s2_needs_out = s2_ok_reg && ((s2_kind_reg == KIND_ENCODE) || (s2_kind_reg == KIND_FLUSH));
    assign s2_fire      = s2_valid_reg && (!s2_needs_out || buf_free);
    assign s1_adv       = !s2_valid_reg || s2_fire;
    assign item_ready   = !s1_valid_reg || s1_adv;

    // a flush never looks at the symbol
    assign s1_ok   = (s1_item_reg.kind == KIND_FLUSH)
                     || (((s1_item_reg.kind == KIND_LOAD) || (s1_item_reg.kind == KIND_ENCODE))
                         && ({2'b00, s1_item_reg.symbol} < 9'(ALPHABET_SIZE)));
    assign s1_idx  = s1_item_reg.symbol[IDX_W-1:0];
    assign s1_len  = (s1_item_reg.code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                                     : s1_item_reg.code_length;
    assign s1_mask = (33'd1 << s1_len) - 33'd1;
    assign s1_code = s1_item_reg.code_bits & s1_mask[CODE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
            pend_reg     <= '0;
            res_left_reg <= '0;
        end
        else
        begin
            if (item_ready)
                s1_valid_reg <= item_valid;
            if (s1_adv)
                s2_valid_reg <= s1_valid_reg;
            acc_reg      <= acc_next;
            pend_reg     <= pend_next;
            res_left_reg <= res_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            s1_item_reg <= item;
        if (s1_adv)
        begin
            s2_kind_reg <= s1_item_reg.kind;
            s2_ok_reg   <= s1_ok;
        end
        for (int i = 0; i < MAX_OUT; i++)
            res_reg[i] <= res_next[i];
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_adv && s1_ok && (s1_item_reg.kind == KIND_LOAD))
        begin
            code_mem[s1_idx] <= s1_code;
            len_mem[s1_idx]  <= s1_len;
        end
        if (s1_adv)
        begin
            code_rd_reg <= code_mem[s1_idx];
            len_rd_reg  <= len_mem[s1_idx];
        end
    end

    always_comb
    begin
        pend_sum   = pend_reg + len_rd_reg;
        acc_sum    = (acc_reg << len_rd_reg) | {{(ACC_W-CODE_W){1'b0}}, code_rd_reg};
        aligned    = acc_sum << (LEN_W'(ACC_W) - pend_sum);
        pend_m1    = pend_sum - LEN_W'(1);
        n_out      = (pend_sum == '0) ? '0 : OUT_CNT_W'(pend_m1 >> 3);
        pend_rem   = pend_sum - (LEN_W'(n_out) << 3);
        flush_byte = acc_reg[BYTE_W-1:0] << (4'd8 - pend_reg[3:0]);
        pad_byte   = BYTE_W'(LEN_W'(BYTE_W) - pend_reg);

        acc_next      = acc_reg;
        pend_next     = pend_reg;
        res_left_next = res_left_reg;
        for (int i = 0; i < MAX_OUT; i++)
            res_next[i] = res_reg[i];

        if (res_take)
        begin
            res_left_next = res_left_reg - OUT_CNT_W'(1);
            for (int i = 0; i < MAX_OUT - 1; i++)
                res_next[i] = res_reg[i + 1];
        end

        if (s2_fire && s2_needs_out)
        begin
            if (s2_kind_reg == KIND_ENCODE)
            begin
                acc_next      = acc_sum & ~({ACC_W{1'b1}} << pend_rem);
                pend_next     = pend_rem;
                res_left_next = n_out;
                for (int i = 0; i < MAX_OUT; i++)
                begin
                    res_next[i].out_byte = aligned[ACC_W-1-BYTE_W*i -: BYTE_W];
                    res_next[i].last     = 1'b0;
                end
            end
            else
            begin
                acc_next             = '0;
                pend_next            = '0;
                res_left_next        = OUT_CNT_W'(2);
                res_next[0].out_byte = flush_byte;
                res_next[0].last     = 1'b0;
                res_next[1].out_byte = pad_byte;
                res_next[1].last     = 1'b1;
            end
        end
    end

    assign result_valid = (res_left_reg != '0);
    assign result       = res_reg[0];

    // pending bits never exceed one byte between transactions
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= LEN_W'(BYTE_W))
        else $error("pending count above one byte");

    // accumulator holds no bits beyond the pending ones
    a_acc_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg >> pend_reg) == '0)
        else $error("stale accumulator bits");

    // the pad-count byte is always the final queued byte
    a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> res_left_reg == OUT_CNT_W'(1))
        else $error("last flagged before queue end");

    // a flush queues exactly two bytes and empties the accumulator
    a_flush_two: assert property (@(posedge clk) disable iff (!rst_n)
        s2_fire && s2_needs_out && (s2_kind_reg == KIND_FLUSH)
        |=> (res_left_reg == OUT_CNT_W'(2)) && (pend_reg == '0))
        else $error("flush did not queue two bytes");

endmodule
